// ===== src/sslc_pkg.sv =====
// package for the subpath speculation log compressor
// holds sizes, operation codes, constants and the controller/datapath command struct
package sslc_pkg;
   localparam int NUM_PATHS = 8;
   localparam int MAX_PATH_LEN = 16;
   localparam int PW = $clog2(NUM_PATHS);
   localparam int EW = $clog2(MAX_PATH_LEN);
   localparam int LW = $clog2(MAX_PATH_LEN + 1);
   localparam int TW = PW + EW;
   localparam int TDEPTH = NUM_PATHS * MAX_PATH_LEN;

   localparam logic [1:0] OP_PROCESS = 2'd0;
   localparam logic [1:0] OP_WR_ENTRY = 2'd1;
   localparam logic [1:0] OP_WR_LEN = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [31:0] COUNTER_INIT = 32'hffff0002;
   localparam logic [31:0] ID_BASE = 32'h11111100;
   localparam logic [31:0] NO_PREV = 32'hffffffff;

   typedef struct packed {
      logic capture;     // latch input transaction
      logic rd_issue;    // issue table reads for path n
      logic match_step;  // evaluate matcher for path n
      logic finish;      // compute result word
      logic [PW-1:0] path;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
   } sts_type;
endpackage

// ===== src/sslc_ram.sv =====
// generic single port write, two port registered read ram
// no dependencies
module sslc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

// ===== src/sslc_ctrl.sv =====
// controller state machine: sequences capture, then for process operations eight matcher steps and result
// depends on sslc_pkg
module sslc_ctrl import sslc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MATCH = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [PW:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_fire, last_step;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   // reads are issued in the cycle before the step that uses them
   assign last_step = step_ff[PW-1:0] == PW'(NUM_PATHS - 1);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      cmd.capture = req_fire;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               step_in = '0;
               cmd.rd_issue = 1'b1;
               cmd.path = '0;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            if (sts.op != OP_PROCESS) begin
               state_in = ST_IDLE;
            end else begin
               cmd.match_step = 1'b1;
               cmd.path = step_ff[PW-1:0];
               if (last_step) begin
                  state_in = ST_DONE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> state_ff == ST_IDLE && !rsp_valid_ff)
      else $error("accept while busy");
   a_done_sets_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid_ff)
      else $error("result not presented");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MATCH |-> step_ff < (PW+1)'(NUM_PATHS))
      else $error("step out of range");
`endif
endmodule

// ===== src/sslc_dp.sv =====
// datapath: path table ram, matcher state and log word selection
// depends on sslc_pkg and sslc_ram
module sslc_dp import sslc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_addr,
   input  logic [2:0]  req_path_sel,
   input  logic [3:0]  req_entry_sel,
   input  logic [15:0] req_log_index,
   input  logic [5:0]  req_bits_left,
   output logic        rsp_speculating,
   output logic [31:0] rsp_log_word,
   output logic [15:0] rsp_log_index_out,
   output logic [5:0]  rsp_bits_left_out
);
   logic [1:0] op_ff;
   logic [31:0] addr_ff;
   logic [15:0] idx_ff;
   logic [5:0] bits_ff;

   logic [LW-1:0] len_ff [NUM_PATHS];
   logic [LW-1:0] cnt_ff [NUM_PATHS];
   logic [15:0] sidx_ff [NUM_PATHS];
   logic [5:0] sbits_ff [NUM_PATHS];
   logic [NUM_PATHS-1:0] mon_ff, det_ff;
   logic [31:0] prev_logged_ff, rcnt_ff;
   logic [15:0] prev_index_ff;
   logic rflag_ff;
   logic restart_ff;

   logic wr_en;
   logic [TW-1:0] wr_addr, rd_a, rd_b;
   logic [31:0] ent_cur, ent_first;
   logic [PW-1:0] n;
   logic [EW-1:0] cnt_sel;

   assign sts.op = op_ff;
   assign n = cmd.path;

   // step n uses reads issued in the previous cycle, so look ahead one path
   logic [PW-1:0] rd_path;
   assign rd_path = cmd.rd_issue ? '0 : PW'(n + 1'b1);
   assign cnt_sel = cnt_ff[rd_path][EW-1:0];
   assign rd_a = {rd_path, cnt_sel};
   assign rd_b = {rd_path, EW'(0)};
   assign wr_en = cmd.capture && req_operation == OP_WR_ENTRY
                  && {1'b0, req_path_sel} < 4'(NUM_PATHS)
                  && {1'b0, req_entry_sel} < 5'(MAX_PATH_LEN);
   assign wr_addr = {req_path_sel[PW-1:0], req_entry_sel[EW-1:0]};

   sslc_ram #(.WIDTH(32), .DEPTH(TDEPTH)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(req_addr),
      .rd_addr_a(rd_a), .rd_data_a(ent_cur), .rd_addr_b(rd_b), .rd_data_b(ent_first)
   );

   // a completion in the previous step cleared every count after this
   // path's read was issued, so compare against its first entry instead
   logic [31:0] ent_cmp;
   logic hit, live, complete;
   assign ent_cmp = restart_ff ? ent_first : ent_cur;
   assign hit = addr_ff == ent_cmp;
   assign live = len_ff[n] != '0 && cnt_ff[n] < len_ff[n];
   assign complete = live && hit && (cnt_ff[n] + 1'b1 == len_ff[n]);

   logic [LW-1:0] len_sat;
   assign len_sat = ({1'b0, req_entry_sel} > 5'(MAX_PATH_LEN)) ? LW'(MAX_PATH_LEN)
                    : LW'(req_entry_sel);

   logic [PW-1:0] first_det;
   logic det_any;
   always_comb begin
      first_det = '0;
      det_any = 1'b0;
      for (int i = NUM_PATHS - 1; i >= 0; i--) begin
         if (det_ff[i]) begin
            first_det = PW'(i);
            det_any = 1'b1;
         end
      end
   end

   logic [31:0] id_word;
   logic [15:0] fidx;
   logic [5:0] fbits;
   assign id_word = ID_BASE | 32'(first_det);
   assign fidx = sidx_ff[first_det];
   assign fbits = sbits_ff[first_det];

   logic [31:0] res_word;
   logic [15:0] res_idx;
   logic [5:0] res_bits;
   always_comb begin
      res_word = addr_ff;
      res_idx = idx_ff;
      res_bits = bits_ff;
      if (det_any) begin
         res_idx = fidx;
         res_bits = fbits;
         if (!rflag_ff && prev_logged_ff != id_word) begin
            res_word = id_word;
         end else if (!rflag_ff) begin
            res_word = rcnt_ff;
         end else if (prev_logged_ff == id_word) begin
            res_idx = prev_index_ff;
            res_word = rcnt_ff + 32'd1;
         end else begin
            res_word = id_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_operation;
         addr_ff <= req_addr;
         idx_ff <= req_log_index;
         bits_ff <= req_bits_left;
      end
      if (cmd.finish) begin
         rsp_speculating <= det_any;
         rsp_log_word <= res_word;
         rsp_log_index_out <= res_idx;
         rsp_bits_left_out <= res_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff <= 1'b0;
      end else begin
         restart_ff <= cmd.match_step && complete;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PATHS; i++) begin
            len_ff[i] <= '0;
            cnt_ff[i] <= '0;
            sidx_ff[i] <= '0;
            sbits_ff[i] <= '0;
         end
         mon_ff <= '0;
         det_ff <= '0;
         prev_logged_ff <= '0;
         prev_index_ff <= '0;
         rflag_ff <= 1'b0;
         rcnt_ff <= COUNTER_INIT;
      end else if (cmd.capture && req_operation == OP_WR_LEN) begin
         if ({1'b0, req_path_sel} < 4'(NUM_PATHS)) begin
            len_ff[req_path_sel[PW-1:0]] <= len_sat;
            cnt_ff[req_path_sel[PW-1:0]] <= '0;
            mon_ff[req_path_sel[PW-1:0]] <= 1'b0;
            sidx_ff[req_path_sel[PW-1:0]] <= '0;
            sbits_ff[req_path_sel[PW-1:0]] <= '0;
         end
      end else if (cmd.capture && req_operation == OP_CLEAR) begin
         for (int i = 0; i < NUM_PATHS; i++) begin
            cnt_ff[i] <= '0;
            sidx_ff[i] <= '0;
            sbits_ff[i] <= '0;
         end
         mon_ff <= '0;
         det_ff <= '0;
         prev_logged_ff <= '0;
         prev_index_ff <= '0;
         rflag_ff <= 1'b0;
         rcnt_ff <= COUNTER_INIT;
      end else if (cmd.match_step) begin
         if (live) begin
            if (hit) begin
               if (cnt_ff[n] == '0) begin
                  sidx_ff[n] <= idx_ff;
                  if (!rflag_ff || prev_logged_ff != (ID_BASE | 32'(n))) begin
                     sbits_ff[n] <= bits_ff;
                  end
               end
               if (complete) begin
                  // completion clears every count and the monitor mask
                  for (int i = 0; i < NUM_PATHS; i++) cnt_ff[i] <= '0;
                  mon_ff <= '0;
                  det_ff <= NUM_PATHS'(1) << n;
               end else begin
                  cnt_ff[n] <= cnt_ff[n] + 1'b1;
                  mon_ff[n] <= 1'b1;
               end
            end else if (mon_ff[n]) begin
               if (addr_ff == ent_first) begin
                  cnt_ff[n] <= LW'(1);
                  sidx_ff[n] <= idx_ff;
                  sbits_ff[n] <= bits_ff;
               end else begin
                  mon_ff[n] <= 1'b0;
                  cnt_ff[n] <= '0;
                  sidx_ff[n] <= '0;
                  sbits_ff[n] <= '0;
               end
            end
         end
      end else if (cmd.finish) begin
         if (!det_any) begin
            if (mon_ff == '0) begin
               rflag_ff <= 1'b0;
               rcnt_ff <= COUNTER_INIT;
               prev_logged_ff <= NO_PREV;
            end
         end else begin
            det_ff[first_det] <= 1'b0;
            if (!rflag_ff && prev_logged_ff != id_word) begin
               prev_logged_ff <= id_word;
               prev_index_ff <= fidx;
            end else if (!rflag_ff) begin
               rflag_ff <= 1'b1;
               prev_index_ff <= fidx;
            end else if (prev_logged_ff == id_word) begin
               rcnt_ff <= rcnt_ff + 32'd1;
            end else begin
               rflag_ff <= 1'b0;
               rcnt_ff <= COUNTER_INIT;
               prev_logged_ff <= id_word;
               prev_index_ff <= fidx;
            end
         end
      end
   end

`ifndef SYNTHESIS
   a_det_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(det_ff))
      else $error("more than one detection pending");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] <= len_ff[0] || len_ff[0] == '0)
      else $error("count above length");
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> det_ff == '0)
      else $error("detection not retired");
`endif
endmodule

// ===== src/subpath_speculation_log_compressor.sv =====
// top level of the subpath speculation log compressor
// depends on sslc_pkg, sslc_ctrl, sslc_dp, sslc_ram
//
// usage:
//   req_ channel carries one transaction: an operation code with its fields.
//   process transactions (op 0) produce exactly one rsp_ transaction; table
//   entry writes, length writes and matcher clears produce none.
//   after a process transaction is accepted the block runs one matcher step
//   per path for eight paths (one path-table read pair per step, issued in the
//   cycle before the step), then forms the word and raises rsp_valid.
//   with rsp_ready held high the next transaction is taken only once the
//   previous process, load or clear transaction has finished.
//   the result sits in an output register; a new request is taken only once
//   it has been delivered, so a stalled rsp_ready holds req_ready low.
//   reset clears lengths, counts, masks and the repeat counter to
//   0xffff0002; the path table itself is not cleared and must be loaded.
module subpath_speculation_log_compressor import sslc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_addr,
   input  logic [2:0]  req_path_sel,
   input  logic [3:0]  req_entry_sel,
   input  logic [15:0] req_log_index,
   input  logic [5:0]  req_bits_left,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_speculating,
   output logic [31:0] rsp_log_word,
   output logic [15:0] rsp_log_index_out,
   output logic [5:0]  rsp_bits_left_out
);
   cmd_type cmd;
   sts_type sts;

   sslc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd)
   );

   sslc_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_operation(req_operation), .req_addr(req_addr),
      .req_path_sel(req_path_sel), .req_entry_sel(req_entry_sel),
      .req_log_index(req_log_index), .req_bits_left(req_bits_left),
      .rsp_speculating(rsp_speculating), .rsp_log_word(rsp_log_word),
      .rsp_log_index_out(rsp_log_index_out), .rsp_bits_left_out(rsp_bits_left_out)
   );
endmodule
